FILE: hdl/avc_pkg.sv
// Shared types and constants for the autokey Vigenere cipher core.
`default_nettype none

package avc_pkg;

  // Alphabet and letter index format.
  localparam int ALPHABET_SIZE = 33;
  localparam int IDX_W         = 6;
  localparam logic [IDX_W-1:0] LETTER_MAX = 6'd32;
  localparam logic [IDX_W-1:0] YO_IDX     = 6'd6;

  // Key storage: sixteen slots of six bits, held in two registers.
  localparam int KEY_SLOTS    = 16;
  localparam int KEY_BITS     = KEY_SLOTS * IDX_W;
  localparam int KEY_LOW_W    = 60;
  localparam int KEY_HIGH_W   = 36;
  localparam int LEN_W        = 5;

  // CP1251 codes used by the letter mapping.
  localparam logic [7:0] CP_YO_UPPER   = 8'hA8;
  localparam logic [7:0] CP_YO_LOWER   = 8'hB8;
  localparam logic [7:0] CP_UPPER_BASE = 8'hC0;
  localparam logic [7:0] CP_UPPER_LAST = 8'hDF;
  localparam logic [7:0] CP_LOWER_BASE = 8'hE0;
  localparam logic [7:0] CP_CASE_DIFF  = 8'h20;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd3;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_letter;
  } out_item_t;

  // Update request from the datapath to the key ring.
  typedef struct packed {
    logic             load;
    logic             step;
    logic [IDX_W-1:0] plain;
  } ring_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/avc_key_ring.sv
// Key ring: autokey letter store with its read pointer and message start load.
`default_nettype none

module avc_key_ring #(
  parameter int KEY_MAX = 16,
  parameter int PTR_W   = 4
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  avc_pkg::ring_ctrl_t                  ctrl_i,
  input  wire                                  first_i,
  input  wire  [avc_pkg::KEY_BITS-1:0]         key_letters_i,
  input  wire  [avc_pkg::LEN_W-1:0]            eff_len_i,
  output logic [avc_pkg::IDX_W-1:0]            key_o
);

  logic [avc_pkg::IDX_W-1:0] ring_q [KEY_MAX];
  logic [avc_pkg::IDX_W-1:0] ring_d [KEY_MAX];
  logic [avc_pkg::IDX_W-1:0] load_val [KEY_MAX];
  logic [PTR_W-1:0]          ptr_q, ptr_d, ptr_cur;
  logic [avc_pkg::LEN_W-1:0] ptr_inc;

  // Key letters as loaded, saturated to the last alphabet index.
  always_comb begin
    for (int i = 0; i < KEY_MAX; i++) begin
      load_val[i] = key_letters_i[i*avc_pkg::IDX_W +: avc_pkg::IDX_W];
      if (load_val[i] > avc_pkg::LETTER_MAX) begin
        load_val[i] = avc_pkg::LETTER_MAX;
      end
    end
  end

  // A message start forces the pointer to slot zero for this beat as well.
  assign ptr_cur = first_i ? '0 : ptr_q;
  assign key_o   = first_i ? load_val[0] : ring_q[ptr_cur];
  assign ptr_inc = avc_pkg::LEN_W'(ptr_cur) + avc_pkg::LEN_W'(1);

  always_comb begin
    for (int i = 0; i < KEY_MAX; i++) begin
      ring_d[i] = ctrl_i.load ? load_val[i] : ring_q[i];
    end
    if (ctrl_i.step) begin
      ring_d[ptr_cur] = ctrl_i.plain;
    end
    ptr_d = ctrl_i.load ? '0 : ptr_q;
    if (ctrl_i.step) begin
      ptr_d = (ptr_inc >= eff_len_i) ? '0 : PTR_W'(ptr_inc);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KEY_MAX; i++) begin
      ring_q[i] <= ring_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/avc_cipher.sv
// Letter mapping and modulo-33 add or subtract for one CP1251 byte.
`default_nettype none

module avc_cipher (
  input  wire  [7:0]                  in_byte_i,
  input  wire                         mode_i,
  input  wire  [avc_pkg::IDX_W-1:0]   key_i,
  output avc_pkg::out_item_t          out_o,
  output logic [avc_pkg::IDX_W-1:0]   plain_o
);

  logic                       lower;
  logic                       letter;
  logic [7:0]                 up_byte;
  logic [7:0]                 offs;
  logic [avc_pkg::IDX_W-1:0]  idx;
  logic [6:0]                 addend;
  logic [6:0]                 sum;
  logic [avc_pkg::IDX_W-1:0]  res;
  logic [7:0]                 enc_byte;

  // Decode: fold lower case onto upper case, Yo sits between E and Zh.
  always_comb begin
    lower   = (in_byte_i == avc_pkg::CP_YO_LOWER) || (in_byte_i >= avc_pkg::CP_LOWER_BASE);
    up_byte = (in_byte_i >= avc_pkg::CP_LOWER_BASE) ? in_byte_i - avc_pkg::CP_CASE_DIFF
                                                    : in_byte_i;
    offs    = up_byte - avc_pkg::CP_UPPER_BASE;
    letter  = 1'b0;
    idx     = '0;
    if ((in_byte_i == avc_pkg::CP_YO_UPPER) || (in_byte_i == avc_pkg::CP_YO_LOWER)) begin
      letter = 1'b1;
      idx    = avc_pkg::YO_IDX;
    end else if ((up_byte >= avc_pkg::CP_UPPER_BASE) &&
                 (up_byte <= avc_pkg::CP_UPPER_LAST)) begin
      letter = 1'b1;
      idx    = (offs < 8'(avc_pkg::YO_IDX)) ? avc_pkg::IDX_W'(offs)
                                            : avc_pkg::IDX_W'(offs + 8'd1);
    end
  end

  // Decrypt adds the complement of the key, so one reduction step suffices.
  always_comb begin
    addend = (mode_i == avc_pkg::MODE_DECRYPT)
             ? 7'(avc_pkg::ALPHABET_SIZE) - 7'(key_i) : 7'(key_i);
    sum    = 7'(idx) + addend;
    res    = (sum >= 7'(avc_pkg::ALPHABET_SIZE))
             ? avc_pkg::IDX_W'(sum - 7'(avc_pkg::ALPHABET_SIZE))
             : avc_pkg::IDX_W'(sum);
    plain_o = (mode_i == avc_pkg::MODE_DECRYPT) ? res : idx;
  end

  // Encode back to CP1251 in the original case.
  always_comb begin
    if (res == avc_pkg::YO_IDX) begin
      enc_byte = lower ? avc_pkg::CP_YO_LOWER : avc_pkg::CP_YO_UPPER;
    end else begin
      enc_byte = (res < avc_pkg::YO_IDX) ? avc_pkg::CP_UPPER_BASE + 8'(res)
                                         : avc_pkg::CP_UPPER_BASE + 8'(res) - 8'd1;
      if (lower) begin
        enc_byte = enc_byte + avc_pkg::CP_CASE_DIFF;
      end
    end
    out_o.is_letter = letter;
    out_o.out_byte  = letter ? enc_byte : in_byte_i;
  end

endmodule

`default_nettype wire

FILE: hdl/autokey_vigenere_cipher_core.sv
// Top level of the autokey Vigenere cipher core for 33-letter Cyrillic text.
//
//   Port group   Direction  Handshake            Beat
//   in_*         input      in_valid_i/in_stall_o   one byte and message start flag
//   out_*        output     out_valid_o/out_stall_i one ciphered byte and letter flag
//   cfg_*        input      cfg_valid_i/cfg_ready_o one register index and its value
//
// One byte is accepted every cycle while the input is not stalled; its result is held in the
// output register once its beat has passed through the input register.
// The rate is set by the key ring read, modulo-33 add and ring write-back, all in the same cycle.
// A stalled output holds its beat, and the input register stalls only while the
// output register is full and stalled. Reset clears the pointer, the pipeline valids
// and the configuration registers; the key ring holds nothing useful until a message start.
`default_nettype none

module autokey_vigenere_cipher_core #(
  parameter int KEY_MAX = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  avc_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output avc_pkg::out_item_t                 out_data_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [avc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [avc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int PTR_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic                            mode_q;
  logic [avc_pkg::LEN_W-1:0]       key_length_q;
  logic [avc_pkg::KEY_LOW_W-1:0]   key_low_q;
  logic [avc_pkg::KEY_HIGH_W-1:0]  key_high_q;
  logic [avc_pkg::LEN_W-1:0]       eff_len;
  logic                            cfg_we;

  logic                            s1_valid_q, s1_valid_d;
  avc_pkg::in_item_t               s1_q;
  logic                            out_valid_q, out_valid_d;
  avc_pkg::out_item_t              out_q;
  logic                            out_free, s1_fire, in_take;

  avc_pkg::out_item_t              cip_out;
  logic [avc_pkg::IDX_W-1:0]       plain;
  logic [avc_pkg::IDX_W-1:0]       key_letter;
  avc_pkg::ring_ctrl_t             ring_ctrl;

  // Configuration.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= avc_pkg::MODE_ENCRYPT;
      key_length_q <= avc_pkg::LEN_W'(1);
      key_low_q    <= '0;
      key_high_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        avc_pkg::CFG_MODE:       mode_q       <= cfg_data_i[0];
        avc_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_data_i[avc_pkg::LEN_W-1:0];
        avc_pkg::CFG_KEY_LOW:    key_low_q    <= cfg_data_i[avc_pkg::KEY_LOW_W-1:0];
        avc_pkg::CFG_KEY_HIGH:   key_high_q   <= cfg_data_i[avc_pkg::KEY_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len = key_length_q;
    if (eff_len == '0) begin
      eff_len = avc_pkg::LEN_W'(1);
    end
    if (eff_len > avc_pkg::LEN_W'(KEY_MAX)) begin
      eff_len = avc_pkg::LEN_W'(KEY_MAX);
    end
  end

  // Pipeline handshake: input register, then result register.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s1_fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_q <= cip_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The ring is only touched on the beat that moves into the result register.
  assign ring_ctrl.load  = s1_fire && s1_q.first;
  assign ring_ctrl.step  = s1_fire && cip_out.is_letter;
  assign ring_ctrl.plain = plain;

  avc_key_ring #(
    .KEY_MAX (KEY_MAX),
    .PTR_W   (PTR_W)
  ) u_key_ring (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ring_ctrl),
    .first_i       (s1_q.first),
    .key_letters_i ({key_high_q, key_low_q}),
    .eff_len_i     (eff_len),
    .key_o         (key_letter)
  );

  avc_cipher u_cipher (
    .in_byte_i (s1_q.in_byte),
    .mode_i    (mode_q),
    .key_i     (key_letter),
    .out_o     (cip_out),
    .plain_o   (plain)
  );

  // Checks.
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register could take a beat");

  a_nonletter_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !cip_out.is_letter) |=>
      (out_valid_o && !out_data_o.is_letter && out_data_o.out_byte == $past(s1_q.in_byte)))
    else $error("non-letter byte was altered");

  a_letter_in_alphabet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_letter) |->
      (out_data_o.out_byte >= avc_pkg::CP_UPPER_BASE ||
       out_data_o.out_byte == avc_pkg::CP_YO_UPPER ||
       out_data_o.out_byte == avc_pkg::CP_YO_LOWER))
    else $error("ciphered letter falls outside the alphabet");

endmodule

`default_nettype wire
